// ===== design/hkst_pkg.sv =====
// Shared types and codes for the held key set tracker.
package hkst_pkg;

   localparam int SLOT_BITS   = 4;
   localparam int STATUS_BITS = 3;
   localparam int TYPE_BITS   = 2;
   localparam int PORT_CODE_BITS = 10;
   localparam int COUNT_OUT_BITS = 5;
   localparam int TOTAL_BITS  = 32;

   typedef enum logic [TYPE_BITS-1:0] {
      OP_RELEASE = 2'd0,
      OP_PRESS   = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ADDED    = 3'd0,
      ST_REMOVED  = 3'd1,
      ST_DUP      = 3'd2,
      ST_DROPPED  = 3'd3,
      ST_ORPHAN   = 3'd4,
      ST_CLEARED  = 3'd5,
      ST_READ_OK  = 3'd6,
      ST_EMPTY    = 3'd7
   } status_type;

   typedef enum logic {
      BK_WAIT  = 1'b0,
      BK_APPLY = 1'b1
   } back_state_type;

   typedef struct packed {
      op_type                op;
      logic [SLOT_BITS-1:0]  slot;
   } cmd_ctl_type;

endpackage

// ===== design/hkst_front.sv =====
// Front end: accepts request words, decodes the request type and narrows the key code.
module hkst_front #(
   parameter int KEY_CODE_BITS = 10
) (
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [hkst_pkg::TYPE_BITS-1:0]        req_type,
   input  logic [hkst_pkg::PORT_CODE_BITS-1:0]   req_key_code,
   input  logic [hkst_pkg::SLOT_BITS-1:0]        req_slot,
   input  logic                                  q_full,
   output logic                                  q_push,
   output hkst_pkg::cmd_ctl_type                 q_ctl,
   output logic [KEY_CODE_BITS-1:0]              q_code
);

   // Zero-extended copy so that the code can be cut to any storage width.
   logic [KEY_CODE_BITS+hkst_pkg::PORT_CODE_BITS-1:0] code_wide;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign code_wide = {{KEY_CODE_BITS{1'b0}}, req_key_code};
   assign q_code    = code_wide[KEY_CODE_BITS-1:0];

   always_comb begin
      q_ctl.slot = req_slot;
      unique case (req_type)
         hkst_pkg::OP_RELEASE: begin
            q_ctl.op = hkst_pkg::OP_RELEASE;
         end
         hkst_pkg::OP_PRESS: begin
            q_ctl.op = hkst_pkg::OP_PRESS;
         end
         hkst_pkg::OP_CLEAR: begin
            q_ctl.op = hkst_pkg::OP_CLEAR;
         end
         default: begin
            q_ctl.op = hkst_pkg::OP_READ;
         end
      endcase
   end

endmodule

// ===== design/hkst_queue.sv =====
// Two-entry command queue between the front end and the list engine.
module hkst_queue #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/hkst_back.sv =====
// List engine: held key list, compaction, counters and the result register.
module hkst_back #(
   parameter int KEY_CAPACITY  = 16,
   parameter int KEY_CODE_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  hkst_pkg::cmd_ctl_type                  q_ctl,
   input  logic [KEY_CODE_BITS-1:0]               q_code,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [hkst_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [hkst_pkg::COUNT_OUT_BITS-1:0]    rsp_held_count,
   output logic [hkst_pkg::PORT_CODE_BITS-1:0]    rsp_key_out,
   output logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_duplicate_press_total,
   output logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_dropped_press_total,
   output logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_orphan_release_total
);

   localparam int CNT_BITS = $clog2(KEY_CAPACITY + 1);
   localparam int IDX_BITS = (KEY_CAPACITY > 1) ? $clog2(KEY_CAPACITY) : 1;
   localparam int TB       = hkst_pkg::TOTAL_BITS;
   localparam int OB       = hkst_pkg::PORT_CODE_BITS;

   hkst_pkg::back_state_type  state_ff;
   hkst_pkg::back_state_type  state_in;

   logic [KEY_CODE_BITS-1:0]  keys_ff [KEY_CAPACITY];
   logic [KEY_CODE_BITS-1:0]  keys_in [KEY_CAPACITY];
   logic [CNT_BITS-1:0]       total_ff;
   logic [CNT_BITS-1:0]       total_in;
   logic [TB-1:0]             dup_ff;
   logic [TB-1:0]             dup_in;
   logic [TB-1:0]             drop_ff;
   logic [TB-1:0]             drop_in;
   logic [TB-1:0]             orphan_ff;
   logic [TB-1:0]             orphan_in;

   hkst_pkg::cmd_ctl_type     ctl_ff;
   hkst_pkg::cmd_ctl_type     ctl_in;
   logic [KEY_CODE_BITS-1:0]  code_ff;
   logic [KEY_CODE_BITS-1:0]  code_in;
   logic                      hit_ff;
   logic                      hit_in;
   logic [IDX_BITS-1:0]       pos_ff;
   logic [IDX_BITS-1:0]       pos_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   hkst_pkg::status_type      status_ff;
   hkst_pkg::status_type      status_in;
   logic [OB-1:0]             key_out_ff;
   logic [OB-1:0]             key_out_in;

   logic                      cmp_hit;
   logic [IDX_BITS-1:0]       cmp_pos;
   logic [31:0]               slot_wide;
   logic [KEY_CODE_BITS-1:0]  key_sel;
   logic [KEY_CODE_BITS+OB-1:0]                   key_wide;
   logic [CNT_BITS+hkst_pkg::COUNT_OUT_BITS-1:0]  count_wide;

   // Parallel compare against the live part of the list. Held codes are unique,
   // so at most one entry matches and its index is a plain OR of the hits.
   always_comb begin
      cmp_hit = 1'b0;
      cmp_pos = '0;
      for (int i = 0; i < KEY_CAPACITY; i++) begin
         if ((CNT_BITS'(i) < total_ff) && (keys_ff[i] == q_code)) begin
            cmp_hit = 1'b1;
            cmp_pos = cmp_pos | IDX_BITS'(i);
         end
      end
   end

   // Slot read mux for read requests.
   always_comb begin
      slot_wide = 32'(ctl_ff.slot);
      key_sel   = '0;
      for (int i = 0; i < KEY_CAPACITY; i++) begin
         if (slot_wide == 32'(i)) begin
            key_sel = keys_ff[i];
         end
      end
      key_wide = {{OB{1'b0}}, key_sel};
   end

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      keys_in      = keys_ff;
      total_in     = total_ff;
      dup_in       = dup_ff;
      drop_in      = drop_ff;
      orphan_in    = orphan_ff;
      ctl_in       = ctl_ff;
      code_in      = code_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      key_out_in   = key_out_ff;

      unique case (state_ff)
         hkst_pkg::BK_WAIT: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ctl_in   = q_ctl;
               code_in  = q_code;
               hit_in   = cmp_hit;
               pos_in   = cmp_pos;
               state_in = hkst_pkg::BK_APPLY;
            end
         end
         hkst_pkg::BK_APPLY: begin
            // The list and counters only move when the result register is free,
            // so the result ports can show the live counters directly.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               key_out_in   = '0;
               state_in     = hkst_pkg::BK_WAIT;
               unique case (ctl_ff.op)
                  hkst_pkg::OP_PRESS: begin
                     if (hit_ff) begin
                        dup_in    = dup_ff + TB'(1);
                        status_in = hkst_pkg::ST_DUP;
                     end else if (total_ff >= CNT_BITS'(KEY_CAPACITY)) begin
                        drop_in   = drop_ff + TB'(1);
                        status_in = hkst_pkg::ST_DROPPED;
                     end else begin
                        for (int i = 0; i < KEY_CAPACITY; i++) begin
                           if (CNT_BITS'(i) == total_ff) begin
                              keys_in[i] = code_ff;
                           end
                        end
                        total_in  = total_ff + CNT_BITS'(1);
                        status_in = hkst_pkg::ST_ADDED;
                     end
                  end
                  hkst_pkg::OP_RELEASE: begin
                     if (hit_ff) begin
                        for (int i = 0; i < KEY_CAPACITY - 1; i++) begin
                           if (IDX_BITS'(i) >= pos_ff) begin
                              keys_in[i] = keys_ff[i+1];
                           end
                        end
                        total_in  = total_ff - CNT_BITS'(1);
                        status_in = hkst_pkg::ST_REMOVED;
                     end else begin
                        orphan_in = orphan_ff + TB'(1);
                        status_in = hkst_pkg::ST_ORPHAN;
                     end
                  end
                  hkst_pkg::OP_CLEAR: begin
                     total_in  = '0;
                     status_in = hkst_pkg::ST_CLEARED;
                  end
                  default: begin
                     if (32'(total_ff) > slot_wide) begin
                        key_out_in = key_wide[OB-1:0];
                        status_in  = hkst_pkg::ST_READ_OK;
                     end else begin
                        status_in  = hkst_pkg::ST_EMPTY;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = hkst_pkg::BK_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hkst_pkg::BK_WAIT;
         total_ff     <= '0;
         dup_ff       <= '0;
         drop_ff      <= '0;
         orphan_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         dup_ff       <= dup_in;
         drop_ff      <= drop_in;
         orphan_ff    <= orphan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      keys_ff    <= keys_in;
      ctl_ff     <= ctl_in;
      code_ff    <= code_in;
      hit_ff     <= hit_in;
      pos_ff     <= pos_in;
      status_ff  <= status_in;
      key_out_ff <= key_out_in;
   end

   assign count_wide                = {{hkst_pkg::COUNT_OUT_BITS{1'b0}}, total_ff};
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = status_ff;
   assign rsp_held_count            = count_wide[hkst_pkg::COUNT_OUT_BITS-1:0];
   assign rsp_key_out               = key_out_ff;
   assign rsp_duplicate_press_total = dup_ff;
   assign rsp_dropped_press_total   = drop_ff;
   assign rsp_orphan_release_total  = orphan_ff;

endmodule

// ===== design/held_key_set_tracker_top.sv =====
// A request word passes through the queue, the list engine's command registers
// and the result register before its result is valid. The engine takes one word
// at a time: a key compare as it pops, then the update and the result load.
// A two-entry queue lets the front end keep accepting while a result waits.
// Reset clears the held count, the three counters, the queue and the result valid;
// the key list itself is not cleared, as only entries below the held count are used.
module held_key_set_tracker_top #(
   parameter int KEY_CAPACITY  = 16,
   parameter int KEY_CODE_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [hkst_pkg::TYPE_BITS-1:0]         req_type,
   input  logic [hkst_pkg::PORT_CODE_BITS-1:0]    req_key_code,
   input  logic [hkst_pkg::SLOT_BITS-1:0]         req_slot,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [hkst_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [hkst_pkg::COUNT_OUT_BITS-1:0]    rsp_held_count,
   output logic [hkst_pkg::PORT_CODE_BITS-1:0]    rsp_key_out,
   output logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_duplicate_press_total,
   output logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_dropped_press_total,
   output logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_orphan_release_total
);

   localparam int CMD_BITS = $bits(hkst_pkg::cmd_ctl_type) + KEY_CODE_BITS;

   logic                      q_full;
   logic                      q_push;
   logic                      q_pop;
   logic                      q_valid;
   hkst_pkg::cmd_ctl_type     push_ctl;
   logic [KEY_CODE_BITS-1:0]  push_code;
   hkst_pkg::cmd_ctl_type     pop_ctl;
   logic [KEY_CODE_BITS-1:0]  pop_code;
   logic [CMD_BITS-1:0]       pop_data;

   hkst_front #(
      .KEY_CODE_BITS (KEY_CODE_BITS)
   ) u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_key_code (req_key_code),
      .req_slot     (req_slot),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_ctl        (push_ctl),
      .q_code       (push_code)
   );

   hkst_queue #(
      .WIDTH (CMD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_ctl, push_code}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   assign {pop_ctl, pop_code} = pop_data;

   hkst_back #(
      .KEY_CAPACITY  (KEY_CAPACITY),
      .KEY_CODE_BITS (KEY_CODE_BITS)
   ) u_back (
      .clock                     (clock),
      .reset                     (reset),
      .q_valid                   (q_valid),
      .q_ctl                     (pop_ctl),
      .q_code                    (pop_code),
      .q_pop                     (q_pop),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_status                (rsp_status),
      .rsp_held_count            (rsp_held_count),
      .rsp_key_out               (rsp_key_out),
      .rsp_duplicate_press_total (rsp_duplicate_press_total),
      .rsp_dropped_press_total   (rsp_dropped_press_total),
      .rsp_orphan_release_total  (rsp_orphan_release_total)
   );

endmodule

// ===== design/hkst_checker.sv =====
// Port-level checks for the held key set tracker, bound to the top level.
module hkst_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [hkst_pkg::TYPE_BITS-1:0]         req_type,
   input  logic [hkst_pkg::PORT_CODE_BITS-1:0]    req_key_code,
   input  logic [hkst_pkg::SLOT_BITS-1:0]         req_slot,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [hkst_pkg::STATUS_BITS-1:0]       rsp_status,
   input  logic [hkst_pkg::COUNT_OUT_BITS-1:0]    rsp_held_count,
   input  logic [hkst_pkg::PORT_CODE_BITS-1:0]    rsp_key_out,
   input  logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_duplicate_press_total,
   input  logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_dropped_press_total,
   input  logic [hkst_pkg::TOTAL_BITS-1:0]        rsp_orphan_release_total
);

   // A stalled request word holds all of its fields.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_type) &&
      $stable(req_key_code) && $stable(req_slot))
      else $error("request word changed while stalled");

   // A stalled result word holds all of its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_key_out) && $stable(rsp_held_count) &&
      $stable(rsp_duplicate_press_total) && $stable(rsp_dropped_press_total) &&
      $stable(rsp_orphan_release_total))
      else $error("result word changed while stalled");

   // No result word comes out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only a successful read carries a key code.
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != hkst_pkg::ST_READ_OK) |-> rsp_key_out == '0)
      else $error("key code on a result that is not a read");

   // A clear always leaves the list empty.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == hkst_pkg::ST_CLEARED) |-> rsp_held_count == '0)
      else $error("held count not zero after clear");

endmodule

bind held_key_set_tracker_top hkst_checker u_hkst_checker (.*);
